@@ hdl/mpjs_pkg.sv @@
// Shared types, codes and constants for the multi-policy job scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mpjs_pkg;

    localparam int MAX_JOBS_DEF  = 16;
    localparam int WORK_BITS_DEF = 16;

    localparam int FIELD_W    = 16;
    localparam int PRIO_W     = 8;
    localparam int EIDX_W     = 4;
    localparam int SEL_W      = 4;
    localparam int POL_W      = 3;
    localparam int JCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT = 1'b1;

    localparam logic [POL_W-1:0] POL_INDEX = 3'd0;
    localparam logic [POL_W-1:0] POL_FIFO  = 3'd1;
    localparam logic [POL_W-1:0] POL_SJF   = 3'd2;
    localparam logic [POL_W-1:0] POL_PSJF  = 3'd3;
    localparam logic [POL_W-1:0] POL_SRTF  = 3'd4;
    localparam logic [POL_W-1:0] POL_RR    = 3'd5;
    localparam logic [POL_W-1:0] POL_PRIO  = 3'd6;

    typedef enum logic [1:0] {
        JS_NONE = 2'd0,
        JS_WAIT = 2'd1,
        JS_RUN  = 2'd2,
        JS_DONE = 2'd3
    } job_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CREDIT,
        ST_INIT,
        ST_SCAN,
        ST_MOD,
        ST_RR,
        ST_COMMIT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic load_write;
        logic credit;
        logic scan_init;
        logic scan_step;
        logic mod_init;
        logic mod_step;
        logic rr_init;
        logic rr_step;
        logic commit;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic need_rr;
        logic mod_done;
        logic rr_done;
        logic is_tick;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/mpjs_ctrl.sv @@
// Controller state machine sequencing load, credit, scan, modulo, circular scan, commit and result steps.
`timescale 1ns / 1ps
`default_nettype none
module mpjs_ctrl
    import mpjs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     opcode,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          in_stall
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (opcode == OP_TICK) ? ST_CREDIT : ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_INIT;
            ST_CREDIT: state_next = ST_INIT;
            ST_INIT:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    if (!stat.is_tick)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (stat.need_rr)
                    begin
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = ST_RR;
                end
            end
            ST_RR:
            begin
                if (stat.rr_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_LOAD:   cmd.load_write = 1'b1;
            ST_CREDIT: cmd.credit     = 1'b1;
            ST_INIT:   cmd.scan_init  = 1'b1;
            ST_SCAN:
            begin
                cmd.scan_step = !stat.scan_end;
                cmd.mod_init  = stat.scan_end && stat.is_tick && stat.need_rr;
            end
            ST_MOD:
            begin
                cmd.mod_step = !stat.mod_done;
                cmd.rr_init  = stat.mod_done;
            end
            ST_RR:     cmd.rr_step = !stat.rr_done;
            ST_COMMIT: cmd.commit  = 1'b1;
            ST_FINISH: cmd.emit    = stat.out_free;
            default:   cmd         = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/mpjs_datapath.sv @@
// Job table, scan and selection datapath with the result register.
`timescale 1ns / 1ps
`default_nettype none
module mpjs_datapath
    import mpjs_pkg::*;
#(
    parameter int MAX_JOBS  = MAX_JOBS_DEF,
    parameter int WORK_BITS = WORK_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  opcode,
    input  wire logic [EIDX_W-1:0]     entry_index,
    input  wire logic [FIELD_W-1:0]    job_workload,
    input  wire logic [PRIO_W-1:0]     job_priority,
    input  wire logic [FIELD_W-1:0]    arrival_quantum,
    input  wire logic [FIELD_W-1:0]    work_done,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [SEL_W-1:0]           selected_job,
    output logic                       dispatched,
    output logic                       switched,
    output logic                       all_done,
    output logic [FIELD_W-1:0]         quantum_now
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int KEY_W = (WORK_BITS > FIELD_W) ? WORK_BITS : FIELD_W;
    localparam int SUM_W = KEY_W + 1;
    localparam int N_W   = (CNT_W > JCNT_W) ? CNT_W : JCNT_W;
    localparam logic [WORK_BITS-1:0] WORK_MAX = '1;

    // captured item
    logic                 op_reg;
    logic [EIDX_W-1:0]    eidx_reg;
    logic [WORK_BITS-1:0] wl_reg;
    logic [PRIO_W-1:0]    pr_reg;
    logic [FIELD_W-1:0]   arr_reg;
    logic [FIELD_W-1:0]   wd_reg;

    // job table
    job_state_t           status_reg [MAX_JOBS];
    logic [WORK_BITS-1:0] exec_reg   [MAX_JOBS];
    logic [WORK_BITS-1:0] total_reg  [MAX_JOBS];
    logic [PRIO_W-1:0]    prio_reg   [MAX_JOBS];
    logic [FIELD_W-1:0]   arrival_reg[MAX_JOBS];

    logic [IDX_W-1:0]     running_reg;
    logic [FIELD_W-1:0]   quantum_reg;
    logic [POL_W-1:0]     policy_reg;
    logic [JCNT_W-1:0]    jcount_reg;

    // per-tick working state
    logic [IDX_W-1:0]     prev_reg;
    logic                 was_run_reg;
    logic                 intr_reg;
    logic [KEY_W-1:0]     lim_reg;
    logic                 lim_valid_reg;
    logic [PRIO_W-1:0]    prev_prio_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     best_reg;
    logic                 best_valid_reg;
    logic [KEY_W-1:0]     bk_reg;
    logic                 bk_valid_reg;
    logic                 alldone_reg;
    logic [CNT_W-1:0]     mod_reg;
    logic [IDX_W-1:0]     rr_idx_reg;
    logic [CNT_W-1:0]     rr_cnt_reg;
    logic                 rr_found_reg;
    logic [IDX_W-1:0]     rr_sel_reg;
    logic                 sw_reg;

    // result register
    logic                 out_valid_reg;
    logic [SEL_W-1:0]     sel_out_reg;
    logic                 disp_out_reg;
    logic                 sw_out_reg;
    logic                 done_out_reg;
    logic [FIELD_W-1:0]   q_out_reg;

    logic [CNT_W-1:0]     n_jobs;
    logic                 eidx_ok;
    logic [IDX_W-1:0]     widx;
    logic                 cur_run;
    logic [SUM_W-1:0]     ex_sum;
    logic [WORK_BITS-1:0] ex_sat;
    logic                 ex_fin;
    logic [WORK_BITS-1:0] rem_new;
    logic [IDX_W-1:0]     si;
    logic [WORK_BITS-1:0] rem_i;
    logic [KEY_W-1:0]     key_i;
    job_state_t           eff_st;
    logic                 take;
    logic                 rr_hit;
    logic [IDX_W-1:0]     rr_next;
    logic                 sel_valid;
    logic [IDX_W-1:0]     sel;
    logic                 now_run;
    logic [31:0]          run_ext;

    always_comb
    begin
        if (N_W'(jcount_reg) > N_W'(MAX_JOBS))
        begin
            n_jobs = CNT_W'(MAX_JOBS);
        end
        else
        begin
            n_jobs = CNT_W'(jcount_reg);
        end
    end

    assign eidx_ok = 32'(eidx_reg) < 32'(MAX_JOBS);
    assign widx    = IDX_W'(eidx_reg);

    // credit of the running job
    assign cur_run = (CNT_W'(running_reg) < n_jobs) && (status_reg[running_reg] == JS_RUN);
    assign ex_sum  = SUM_W'(exec_reg[running_reg]) + SUM_W'(wd_reg);
    assign ex_sat  = (ex_sum > SUM_W'(WORK_MAX)) ? WORK_MAX : ex_sum[WORK_BITS-1:0];
    assign ex_fin  = ex_sat >= total_reg[running_reg];
    assign rem_new = ex_fin ? '0 : (total_reg[running_reg] - ex_sat);

    // scan element
    assign si    = cnt_reg[IDX_W-1:0];
    assign rem_i = (exec_reg[si] < total_reg[si]) ? (total_reg[si] - exec_reg[si]) : '0;

    always_comb
    begin
        case (policy_reg)
            POL_FIFO:           key_i = KEY_W'(arrival_reg[si]);
            POL_SJF, POL_PSJF:  key_i = KEY_W'(total_reg[si]);
            POL_SRTF:           key_i = KEY_W'(rem_i);
            POL_PRIO:           key_i = KEY_W'(prio_reg[si]);
            default:            key_i = '0;
        endcase
    end

    always_comb
    begin
        eff_st = status_reg[si];
        if (op_reg == OP_TICK && status_reg[si] == JS_NONE && arrival_reg[si] == quantum_reg)
        begin
            eff_st = JS_WAIT;
        end
    end

    assign take    = (eff_st == JS_WAIT) && (!bk_valid_reg || key_i < bk_reg);
    assign rr_hit  = (status_reg[rr_idx_reg] == JS_WAIT) &&
                     ((policy_reg != POL_PRIO) || (prio_reg[rr_idx_reg] == prev_prio_reg));
    assign rr_next = ((CNT_W'(rr_idx_reg) + CNT_W'(1)) == n_jobs) ? '0 : rr_idx_reg + IDX_W'(1);

    always_comb
    begin
        sel_valid = best_valid_reg;
        sel       = best_reg;
        case (policy_reg)
            POL_FIFO, POL_SJF:
            begin
                if (intr_reg)
                begin
                    sel_valid = 1'b1;
                    sel       = prev_reg;
                end
            end
            POL_PSJF, POL_SRTF:
            begin
                if (intr_reg)
                begin
                    sel_valid = 1'b1;
                    sel       = best_valid_reg ? best_reg : prev_reg;
                end
            end
            POL_RR:
            begin
                sel_valid = rr_found_reg;
                sel       = rr_sel_reg;
            end
            POL_PRIO:
            begin
                if (best_valid_reg && best_reg == prev_reg)
                begin
                    sel_valid = rr_found_reg;
                    sel       = rr_sel_reg;
                end
            end
            default:
            begin
                sel_valid = best_valid_reg;
                sel       = best_reg;
            end
        endcase
    end

    assign now_run = (CNT_W'(running_reg) < n_jobs) && (status_reg[running_reg] == JS_RUN);
    assign run_ext = 32'(running_reg);

    assign stat.scan_end = (cnt_reg == n_jobs);
    assign stat.need_rr  = (n_jobs != '0) &&
                           ((policy_reg == POL_RR) ||
                            (policy_reg == POL_PRIO && best_valid_reg && best_reg == prev_reg));
    assign stat.mod_done = mod_reg < n_jobs;
    assign stat.rr_done  = rr_found_reg || (rr_cnt_reg == n_jobs);
    assign stat.is_tick  = (op_reg == OP_TICK);
    assign stat.out_free = !out_valid_reg || !out_stall;

    // item capture, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            eidx_reg <= entry_index;
            wl_reg   <= WORK_BITS'(job_workload);
            pr_reg   <= job_priority;
            arr_reg  <= arrival_quantum;
            wd_reg   <= work_done;
        end
    end

    // payload columns of the table
    always_ff @(posedge clk)
    begin
        if (cmd.load_write && eidx_ok)
        begin
            total_reg[widx]   <= wl_reg;
            prio_reg[widx]    <= pr_reg;
            arrival_reg[widx] <= arr_reg;
        end
    end

    // status and executed work
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                status_reg[i] <= JS_NONE;
                exec_reg[i]   <= '0;
            end
        end
        else if (cmd.load_write)
        begin
            if (eidx_ok)
            begin
                status_reg[widx] <= JS_NONE;
                exec_reg[widx]   <= '0;
            end
        end
        else if (cmd.credit)
        begin
            if (cur_run)
            begin
                exec_reg[running_reg]   <= ex_sat;
                status_reg[running_reg] <= ex_fin ? JS_DONE : JS_WAIT;
            end
        end
        else if (cmd.scan_step)
        begin
            status_reg[si] <= eff_st;
        end
        else if (cmd.commit)
        begin
            if (sel_valid)
            begin
                status_reg[sel] <= JS_RUN;
            end
        end
    end

    // control registers and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= '0;
            quantum_reg    <= '0;
            policy_reg     <= POL_INDEX;
            jcount_reg     <= '0;
            prev_reg       <= '0;
            was_run_reg    <= 1'b0;
            intr_reg       <= 1'b0;
            lim_reg        <= '0;
            lim_valid_reg  <= 1'b0;
            prev_prio_reg  <= '0;
            cnt_reg        <= '0;
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
            bk_reg         <= '0;
            bk_valid_reg   <= 1'b0;
            alldone_reg    <= 1'b0;
            mod_reg        <= '0;
            rr_idx_reg     <= '0;
            rr_cnt_reg     <= '0;
            rr_found_reg   <= 1'b0;
            rr_sel_reg     <= '0;
            sw_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POLICY:    policy_reg <= cfg_wdata[POL_W-1:0];
                    CFG_JOB_COUNT: jcount_reg <= cfg_wdata[JCNT_W-1:0];
                    default:       policy_reg <= policy_reg;
                endcase
            end
            if (cmd.load_write)
            begin
                lim_valid_reg <= 1'b0;
                intr_reg      <= 1'b0;
                sw_reg        <= 1'b0;
            end
            if (cmd.credit)
            begin
                prev_reg      <= running_reg;
                was_run_reg   <= cur_run;
                intr_reg      <= cur_run && !ex_fin;
                prev_prio_reg <= prio_reg[running_reg];
                lim_reg       <= (policy_reg == POL_SRTF) ? KEY_W'(rem_new)
                                                          : KEY_W'(total_reg[running_reg]);
                lim_valid_reg <= cur_run && !ex_fin &&
                                 (policy_reg == POL_PSJF || policy_reg == POL_SRTF);
            end
            if (cmd.scan_init)
            begin
                cnt_reg        <= '0;
                best_valid_reg <= 1'b0;
                bk_reg         <= lim_reg;
                bk_valid_reg   <= lim_valid_reg;
                alldone_reg    <= (n_jobs != '0);
                rr_found_reg   <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (eff_st != JS_DONE)
                begin
                    alldone_reg <= 1'b0;
                end
                if (take)
                begin
                    best_reg       <= si;
                    best_valid_reg <= 1'b1;
                    bk_reg         <= key_i;
                    bk_valid_reg   <= 1'b1;
                end
            end
            // start of the circular scan: (prev + 1) mod n by repeated subtract
            if (cmd.mod_init)
            begin
                mod_reg <= CNT_W'(prev_reg) + CNT_W'(1);
            end
            if (cmd.mod_step)
            begin
                mod_reg <= mod_reg - n_jobs;
            end
            if (cmd.rr_init)
            begin
                rr_idx_reg   <= mod_reg[IDX_W-1:0];
                rr_cnt_reg   <= '0;
                rr_found_reg <= 1'b0;
            end
            if (cmd.rr_step)
            begin
                rr_cnt_reg <= rr_cnt_reg + CNT_W'(1);
                if (rr_hit)
                begin
                    rr_found_reg <= 1'b1;
                    rr_sel_reg   <= rr_idx_reg;
                end
                else
                begin
                    rr_idx_reg <= rr_next;
                end
            end
            if (cmd.commit)
            begin
                if (sel_valid)
                begin
                    running_reg <= sel;
                end
                sw_reg      <= (sel_valid != was_run_reg) || (sel_valid && sel != prev_reg);
                quantum_reg <= quantum_reg + FIELD_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            sel_out_reg  <= now_run ? run_ext[SEL_W-1:0] : '0;
            disp_out_reg <= now_run;
            sw_out_reg   <= sw_reg;
            done_out_reg <= alldone_reg;
            q_out_reg    <= quantum_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign selected_job = sel_out_reg;
    assign dispatched   = disp_out_reg;
    assign switched     = sw_out_reg;
    assign all_done     = done_out_reg;
    assign quantum_now  = q_out_reg;

endmodule
`default_nettype wire

@@ hdl/multi_policy_job_scheduler_top.sv @@
// Top level of the multi-policy job scheduler: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall  | opcode, entry_index, job_workload,
//          |           |                      | job_priority, arrival_quantum, work_done
//  out     | output    | out_valid / out_stall| selected_job, dispatched, switched,
//          |           |                      | all_done, quantum_now
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// One item at a time. A load steps through the load, init, scan and finish states,
// a tick through credit, init, scan, commit and finish. Round robin and priority
// ties add the modulo and circular scans. The table scan takes one entry per cycle.
// Reset clears job status, executed work, running job, quantum and control registers.
// The result register frees the input side: a new beat is taken while the last
// result still waits under out_stall.
`timescale 1ns / 1ps
`default_nettype none
module multi_policy_job_scheduler_top
    import mpjs_pkg::*;
#(
    parameter int MAX_JOBS  = MAX_JOBS_DEF,
    parameter int WORK_BITS = WORK_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  opcode,
    input  wire logic [EIDX_W-1:0]     entry_index,
    input  wire logic [FIELD_W-1:0]    job_workload,
    input  wire logic [PRIO_W-1:0]     job_priority,
    input  wire logic [FIELD_W-1:0]    arrival_quantum,
    input  wire logic [FIELD_W-1:0]    work_done,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [SEL_W-1:0]           selected_job,
    output logic                       dispatched,
    output logic                       switched,
    output logic                       all_done,
    output logic [FIELD_W-1:0]         quantum_now
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence the steps of each beat
    mpjs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // hold the job table, scan it and register the result
    mpjs_datapath #(
        .MAX_JOBS  (MAX_JOBS),
        .WORK_BITS (WORK_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .job_workload    (job_workload),
        .job_priority    (job_priority),
        .arrival_quantum (arrival_quantum),
        .work_done       (work_done),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .selected_job    (selected_job),
        .dispatched      (dispatched),
        .switched        (switched),
        .all_done        (all_done),
        .quantum_now     (quantum_now)
    );

`ifndef SYNTH
    // an accepted beat keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken twice in a row");

    // no running job reads as index zero
    a_idle_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !dispatched) |-> (selected_job == '0))
        else $error("selected_job set without dispatch");

    // when every job is done nothing can be running
    a_done_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && all_done) |-> !dispatched)
        else $error("dispatch reported with all jobs done");
`endif

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the multi-policy job scheduler.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mpjs_pkg::*;

    typedef enum int {KEY_NONE, KEY_ARRIVAL, KEY_TOTAL, KEY_REMAIN, KEY_PRIO} sort_key_t;

    typedef struct {
        logic [SEL_W-1:0]   sel;
        logic               disp;
        logic               sw;
        logic               done;
        logic [FIELD_W-1:0] quantum;
    } sched_result_t;

    localparam int NJOBS    = 16;
    localparam int NO_LIMIT = 1 << 20;
    // drain margin covering the table scan, control states and the modulo and circular scans
    localparam int DRAIN_CYCLES = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic                  opcode;
    logic [EIDX_W-1:0]     entry_index;
    logic [FIELD_W-1:0]    job_workload;
    logic [PRIO_W-1:0]     job_priority;
    logic [FIELD_W-1:0]    arrival_quantum;
    logic [FIELD_W-1:0]    work_done;
    logic                  out_valid;
    logic                  out_stall;
    logic [SEL_W-1:0]      selected_job;
    logic                  dispatched;
    logic                  switched;
    logic                  all_done;
    logic [FIELD_W-1:0]    quantum_now;

    multi_policy_job_scheduler_top dut (.*);

    // Shadow copy of the scheduler state, advanced once per accepted beat.
    job_state_t         sh_status  [NJOBS];
    logic [FIELD_W-1:0] sh_total   [NJOBS];
    logic [FIELD_W-1:0] sh_executed[NJOBS];
    logic [PRIO_W-1:0]  sh_prio    [NJOBS];
    logic [FIELD_W-1:0] sh_arrival [NJOBS];
    logic [3:0]         sh_running;
    logic [FIELD_W-1:0] sh_quantum;
    logic [POL_W-1:0]   sh_policy;
    logic [JCNT_W-1:0]  sh_job_count;

    sched_result_t pending_results[$];

    int errors      = 0;
    int loads_sent  = 0;
    int ticks_sent  = 0;
    int results_ok  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Scheduler prediction
    // ------------------------------------------------------------------
    function automatic int jobs_active();
        return (sh_job_count > NJOBS) ? NJOBS : int'(sh_job_count);
    endfunction

    function automatic int sort_value(int i, sort_key_t kind);
        case (kind)
            KEY_ARRIVAL: return int'(sh_arrival[i]);
            KEY_TOTAL:   return int'(sh_total[i]);
            KEY_REMAIN:  return (sh_executed[i] < sh_total[i]) ?
                                int'(sh_total[i]) - int'(sh_executed[i]) : 0;
            KEY_PRIO:    return int'(sh_prio[i]);
            default:     return 0;
        endcase
    endfunction

    // lowest-index waiting job with the smallest key strictly under limit
    function automatic int pick_lowest(int n, sort_key_t kind, int limit);
        int best;
        int bk;
        best = -1;
        bk = limit;
        for (int i = 0; i < n; i++)
        begin
            if (sh_status[i] == JS_WAIT && sort_value(i, kind) < bk)
            begin
                bk = sort_value(i, kind);
                best = i;
            end
        end
        return best;
    endfunction

    function automatic int next_waiting(int start, int n, bit match, int prio);
        int idx;
        for (int i = 0; i < n; i++)
        begin
            idx = (start + 1 + i) % n;
            if (sh_status[idx] == JS_WAIT && (!match || sh_prio[idx] == prio))
                return idx;
        end
        return -1;
    endfunction

    function automatic sched_result_t schedule_beat(logic op, logic [3:0] idx,
            logic [15:0] wl, logic [7:0] pr, logic [15:0] arr, logic [15:0] wd);
        sched_result_t r;
        int n;
        int prev;
        int sel;
        int ex;
        bit was_running;
        bit interrupted;
        bit now_running;
        bit all_finished;
        n = jobs_active();
        r.sw = 1'b0;
        if (op == OP_LOAD)
        begin
            sh_status[idx]   = JS_NONE;
            sh_total[idx]    = wl;
            sh_executed[idx] = '0;
            sh_prio[idx]     = pr;
            sh_arrival[idx]  = arr;
        end
        else
        begin
            prev = sh_running;
            was_running = prev < n && sh_status[prev] == JS_RUN;
            interrupted = 1'b0;
            // credit work to the running job, saturating
            if (was_running)
            begin
                ex = int'(sh_executed[prev]) + int'(wd);
                if (ex > 65535)
                    ex = 65535;
                sh_executed[prev] = ex[15:0];
                if (ex >= int'(sh_total[prev]))
                    sh_status[prev] = JS_DONE;
                else
                begin
                    sh_status[prev] = JS_WAIT;
                    interrupted = 1'b1;
                end
            end
            // arrivals for this quantum
            for (int i = 0; i < n; i++)
                if (sh_status[i] == JS_NONE && sh_arrival[i] == sh_quantum)
                    sh_status[i] = JS_WAIT;
            case (sh_policy)
                POL_FIFO: sel = interrupted ? prev : pick_lowest(n, KEY_ARRIVAL, NO_LIMIT);
                POL_SJF:  sel = interrupted ? prev : pick_lowest(n, KEY_TOTAL, NO_LIMIT);
                POL_PSJF, POL_SRTF:
                begin
                    sort_key_t kind;
                    kind = (sh_policy == POL_PSJF) ? KEY_TOTAL : KEY_REMAIN;
                    if (interrupted)
                    begin
                        sel = pick_lowest(n, kind, sort_value(prev, kind));
                        if (sel < 0)
                            sel = prev;
                    end
                    else
                        sel = pick_lowest(n, kind, NO_LIMIT);
                end
                POL_RR: sel = next_waiting(prev, n, 1'b0, 0);
                POL_PRIO:
                begin
                    sel = pick_lowest(n, KEY_PRIO, NO_LIMIT);
                    if (sel >= 0 && sel == prev)
                        sel = next_waiting(prev, n, 1'b1, sh_prio[prev]);
                end
                default: sel = pick_lowest(n, KEY_NONE, NO_LIMIT);
            endcase
            if (sel >= 0)
            begin
                sh_status[sel] = JS_RUN;
                sh_running = sel[3:0];
            end
            r.sw = ((sel >= 0) != was_running) || (sel >= 0 && sel != prev);
            sh_quantum = sh_quantum + 16'd1;
        end
        now_running = sh_running < n && sh_status[sh_running] == JS_RUN;
        all_finished = n > 0;
        for (int i = 0; i < n; i++)
            if (sh_status[i] != JS_DONE)
                all_finished = 1'b0;
        r.sel = now_running ? sh_running : '0;
        r.disp = now_running;
        r.done = all_finished;
        r.quantum = sh_quantum;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: compare every accepted beat against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(string name, int expd, int got);
        if (expd != got)
        begin
            $error("%s: expected %0d, got %0d", name, expd, got);
            errors++;
        end
    endtask

    initial
    begin
        sched_result_t e;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    check_field("selected_job", e.sel, selected_job);
                    check_field("dispatched", e.disp, dispatched);
                    check_field("switched", e.sw, switched);
                    check_field("all_done", e.done, all_done);
                    check_field("quantum_now", e.quantum, quantum_now);
                    results_ok++;
                end
            end
        end
    end

    // Receiver back-pressure; a long hold, when requested, is counted down here.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_beat(logic op, logic [3:0] idx, logic [15:0] wl,
            logic [7:0] pr, logic [15:0] arr, logic [15:0] wd);
        @(negedge clk);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        opcode = op;
        entry_index = idx;
        job_workload = wl;
        job_priority = pr;
        arrival_quantum = arr;
        work_done = wd;
        in_valid = 1'b1;
        // hold the beat until the block takes it
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(schedule_beat(op, idx, wl, pr, arr, wd));
        if (op == OP_LOAD)
            loads_sent++;
        else
            ticks_sent++;
    endtask

    task automatic load_job(int idx, int wl, int pr, int arr);
        send_beat(OP_LOAD, idx[3:0], wl[15:0], pr[7:0], arr[15:0], 16'($urandom()));
    endtask

    task automatic tick(int wd);
        send_beat(OP_TICK, 4'($urandom()), 16'($urandom()), 8'($urandom()),
                  16'($urandom()), wd[15:0]);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value[CFG_DATA_W-1:0];
        if (idx == CFG_POLICY)
            sh_policy = value[POL_W-1:0];
        else
            sh_job_count = value[JCNT_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic int random_work();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 8)
            return 65535;
        if (r < 12)
            return $urandom_range(0, 65535);
        return $urandom_range(1, 12);
    endfunction

    function automatic int near_arrival();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 65535);
        return int'(sh_quantum) + $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // empty table: ticks advance the quantum with nothing dispatched
        tick(0);
        tick(16'hFFFF);
        // fill the whole table; extremes on the first and last entries
        load_job(0, 0, 0, 0);
        load_job(15, 65535, 255, 65535);
        for (int i = 1; i < 15; i++)
            load_job(i, i, i % 3, 2 + (i % 4));
        drain();
        write_reg(CFG_JOB_COUNT, 16);
        write_reg(CFG_POLICY, POL_INDEX);
        // full credits end each dispatched job; entries 0 and 15 never arrive in these ticks
        repeat (6) tick(16'hFFFF);
        tick(0);
        drain();
    endtask

    // one phase: configure, load the jobs in use, then mostly ticks with some reloads
    task automatic run_phase(int pol, int jcnt, int items);
        int n;
        drain();
        write_reg(CFG_POLICY, pol);
        write_reg(CFG_JOB_COUNT, jcnt);
        n = (jcnt > NJOBS) ? NJOBS : jcnt;
        for (int i = 0; i < n; i++)
            load_job(i, random_work(), $urandom_range(0, 3), near_arrival());
        for (int k = 0; k < items; k++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 82)
                tick(($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 6));
            else if (r < 95)
                load_job($urandom_range(0, NJOBS - 1), random_work(),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 3),
                         near_arrival());
            else
                send_beat(1'($urandom()), 4'($urandom()), 16'($urandom()),
                          8'($urandom()), 16'($urandom()), 16'($urandom()));
        end
    endtask

    task automatic test_random_traffic();
        int pol;
        int jcnt;
        for (int ph = 0; ph < 24; ph++)
        begin
            if (ph == 8)
            begin
                tx_idle_pct = 61;
                rx_idle_pct = 12;
            end
            else if (ph == 16)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pol = ph % 8;
            case (ph % 6)
                0: jcnt = 16;
                1: jcnt = 1;
                2: jcnt = (ph == 2) ? 31 : 2;
                default: jcnt = $urandom_range(3, 8);
            endcase
            run_phase(pol, jcnt, 75);
        end
    endtask

    // long receiver hold while the sender keeps offering beats
    task automatic test_backpressure();
        run_phase(POL_RR, 4, 5);
        run_phase(POL_PRIO, 6, 20);
        // results are held off while ticks keep coming, so the block fills and stalls
        hold_left = 300;
        for (int k = 0; k < 40; k++)
            tick($urandom_range(0, 6));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        opcode = OP_TICK;
        entry_index = '0;
        job_workload = '0;
        job_priority = '0;
        arrival_quantum = '0;
        work_done = '0;
        for (int i = 0; i < NJOBS; i++)
        begin
            sh_status[i] = JS_NONE;
            sh_total[i] = '0;
            sh_executed[i] = '0;
            sh_prio[i] = '0;
            sh_arrival[i] = '0;
        end
        sh_running = '0;
        sh_quantum = '0;
        sh_policy = POL_INDEX;
        sh_job_count = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 61;
        test_directed();
        test_random_traffic();
        test_backpressure();
        // a zero job count closes the run with idle ticks
        run_phase(POL_INDEX, 0, 4);
        drain();

        $display("Covered all policy codes, job counts 0 to 31, %0d loads and %0d ticks;",
                 loads_sent, ticks_sent);
        $display("%0d result beats checked with idle and stall on both sides.", results_ok);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
